[src/bfsc_pkg.sv]
// Package: shared types, opcodes and constants for the bitmap find-first block.
`default_nettype none
package bfsc_pkg;

	localparam int unsigned BFSC_NUM_BITS = 4096;
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned SEL_W = $clog2(WORD_BITS);
	localparam int unsigned LEN_W = 13;
	localparam int unsigned IDX_W = 12;
	localparam int unsigned OP_W = 3;
	localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

	typedef enum logic [OP_W-1:0] {
		OP_GET       = 3'd0,
		OP_SET       = 3'd1,
		OP_CLEAR     = 3'd2,
		OP_FIND      = 3'd3,
		OP_CLEAR_ALL = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_EVAL,
		ST_WIPE,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [IDX_W-1:0] bit_index;
		logic             find_value;
	} req_t;

	typedef struct packed {
		logic             bit_value;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic             status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic rd;
		logic eval;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic clear_all;
		logic scan_on;
		logic clr_last;
	} sts_t;

endpackage
`default_nettype wire

[src/bfsc_dp.sv]
// Datapath: length register, word store, request registers, find logic and result registers.
`default_nettype none
module bfsc_dp
	import bfsc_pkg::*;
#(
	parameter int unsigned NUM_BITS = BFSC_NUM_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire req_t             req,
	input  wire logic             cfg_we,
	input  wire logic [LEN_W-1:0] cfg_wdata,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	output rsp_t                  rsp
);

	localparam int unsigned STORE_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	logic [WORD_BITS-1:0] mem [STORE_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;

	logic [LEN_W-1:0] len_q;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    ptr_q;
	logic             first_q;
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] idx_q;
	logic             want_q;
	logic             err_q;
	logic             bit_value_q;
	logic             found_q;
	logic [IDX_W-1:0] found_index_q;

	logic [LEN_W-1:0]     eff_len;
	logic [LEN_W:0]       words;
	logic [SEL_W-1:0]     sel;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] bits;
	logic [SEL_W-1:0]     ctz;
	logic                 hit;
	logic                 more;
	logic                 in_len;
	logic                 is_find;
	logic                 indexed_op;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;

	assign eff_len = ({19'd0, len_q} > 32'(NUM_BITS)) ? LEN_W'(NUM_BITS) : len_q;
	assign words = (LEN_W + 1)'(({1'b0, eff_len} + (LEN_W + 1)'(WORD_BITS - 1)) >> SEL_W);
	assign sel = idx_q[SEL_W-1:0];
	assign is_find = (op_q == OP_FIND);
	assign indexed_op = (op_q == OP_GET) || (op_q == OP_SET) || (op_q == OP_CLEAR)
		|| (op_q == OP_FIND);

	assign mask = first_q ? ({WORD_BITS{1'b1}} << sel) : {WORD_BITS{1'b1}};
	assign bits = (want_q ? rd_data_q : ~rd_data_q) & mask;
	assign hit = |bits;

	always_comb begin
		ctz = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (bits[i]) begin
				ctz = SEL_W'(i);
			end
		end
	end

	assign in_len = (32'({ptr_q, ctz}) < 32'(eff_len));
	assign more = ((32'(ptr_q) + 32'd1) < 32'(words));

	assign sts.skip = err_q || !(indexed_op || (op_q == OP_CLEAR_ALL));
	assign sts.clear_all = (op_q == OP_CLEAR_ALL);
	assign sts.scan_on = is_find && !hit && more;
	assign sts.clr_last = (clr_q == AW'(STORE_WORDS - 1));

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = rd_data_q;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (cmd.eval && (op_q == OP_SET)) begin
			mem_we = 1'b1;
			mem_wdata = rd_data_q | (WORD_BITS'(1) << sel);
		end else if (cmd.eval && (op_q == OP_CLEAR)) begin
			mem_we = 1'b1;
			mem_wdata = rd_data_q & ~(WORD_BITS'(1) << sel);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (cmd.capture) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= req.opcode;
			idx_q <= req.bit_index;
			want_q <= req.find_value;
			first_q <= 1'b1;
			ptr_q <= AW'(req.bit_index[IDX_W-1:SEL_W]);
			bit_value_q <= 1'b0;
			found_q <= 1'b0;
			found_index_q <= '0;
			err_q <= 1'b0;
		end
		if (cmd.decode) begin
			err_q <= indexed_op && ({1'b0, idx_q} >= eff_len);
		end
		if (cmd.eval) begin
			if (op_q == OP_GET) begin
				bit_value_q <= rd_data_q[sel];
			end
			if (is_find) begin
				if (hit) begin
					if (in_len) begin
						found_q <= 1'b1;
						found_index_q <= IDX_W'({ptr_q, ctz});
					end
				end else begin
					ptr_q <= ptr_q + AW'(1);
					first_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.bit_value = bit_value_q;
	assign rsp.found = found_q;
	assign rsp.found_index = found_index_q;
	assign rsp.status = err_q;

endmodule
`default_nettype wire

[src/bfsc_ctrl.sv]
// Controller: state machine that sequences requests, word scans and store clearing.
`default_nettype none
module bfsc_ctrl
	import bfsc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy,
	output logic      done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				if (sts.skip) begin
					state_d = ST_REPLY;
				end else if (sts.clear_all) begin
					state_d = ST_WIPE;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = sts.scan_on ? ST_READ : ST_REPLY;
			end
			ST_WIPE: begin
				if (sts.clr_last) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			ST_WIPE: begin
				cmd.clr_step = 1'b1;
			end
			ST_REPLY: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("Result strobe outside a busy request.");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("Result strobe longer than one cycle.");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("Block still busy after the result.");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_DECODE))
		else $error("Accepted request did not reach decode.");
	a_eval_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> ($past(state_q) == ST_READ))
		else $error("Word evaluated without a preceding read.");
`endif

endmodule
`default_nettype wire

[src/bitmap_find_first_set_clear.sv]
// Top level: bit array store with get, set, clear, find-first-from-index and clear all.
//
//  Channel   Ports                 Handshake
//  request   start, busy, req      taken when start is high and busy is low
//  result    done, rsp             valid for the one cycle that done is high
//  config    cfg_we, cfg_wdata     bit_length written when cfg_we is high
//
// A get, set or clear passes through decode, read, evaluation and reply; an index error
// or an unused opcode goes from the read state straight to reply. A find reads and then
// evaluates each word that it scans, one read and one evaluation per word of the store,
// which is read and written in separate states. Clear all wipes one word per cycle.
// After each result the block returns to idle. After reset the store is cleared with
// busy held high. The receiver cannot stall: each result is shown once.
`default_nettype none
module bitmap_find_first_set_clear
	import bfsc_pkg::*;
#(
	parameter int unsigned NUM_BITS = BFSC_NUM_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             req,
	output logic                  done,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic [LEN_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	bfsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bfsc_dp #(
		.NUM_BITS (NUM_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
